### hw/rtl/llbc_pkg.sv
package llbc_pkg;

  // Shared multiply-divide unit: q = (a * b) / d, truncated
  localparam int unsigned A_W   = 22;  // block sum at the largest block size
  localparam int unsigned B_W   = 12;
  localparam int unsigned D_W   = 12;
  localparam int unsigned NUM_W = 24;  // every product stays below 2**24
  localparam int unsigned Q_W   = 12;  // every quotient stays below 2**12

  // Every divisor is a constant: the estimate (a * b * m) >> RCP_SH with
  // m = 2**RCP_SH / d is low by at most one while a * b < 2**RCP_SH, and one
  // compare against the remainder fixes it.
  localparam int unsigned RCP_SH = 24;
  localparam int unsigned RCP_W  = 25;  // m = 2**24 for d = 1

  localparam logic [RCP_W-1:0] RCP_4095 = RCP_W'((1 << RCP_SH) / 4095);
  localparam logic [RCP_W-1:0] RCP_3133 = RCP_W'((1 << RCP_SH) / 3133);
  localparam logic [RCP_W-1:0] RCP_3300 = RCP_W'((1 << RCP_SH) / 3300);
  localparam logic [RCP_W-1:0] RCP_662  = RCP_W'((1 << RCP_SH) / 662);
  localparam logic [RCP_W-1:0] RCP_349  = RCP_W'((1 << RCP_SH) / 349);
  localparam logic [RCP_W-1:0] RCP_627  = RCP_W'((1 << RCP_SH) / 627);
  localparam logic [RCP_W-1:0] RCP_655  = RCP_W'((1 << RCP_SH) / 655);
  localparam logic [RCP_W-1:0] RCP_415  = RCP_W'((1 << RCP_SH) / 415);

  typedef struct packed {
    logic             start;
    logic [A_W-1:0]   a;
    logic [B_W-1:0]   b;
    logic [D_W-1:0]   d;
    logic [RCP_W-1:0] m;
  } llbc_req_t;

  typedef struct packed {
    logic             done;
    logic [Q_W-1:0]   q;
  } llbc_rsp_t;

  // Register map, index = paddr[3:2]
  localparam logic [1:0] REG_DESIRED  = 2'd0;
  localparam logic [1:0] REG_ACTIVE   = 2'd1;
  localparam logic [1:0] REG_DEADBAND = 2'd2;

endpackage

### hw/rtl/light_level_block_controller.sv
// Light level block controller.
// Input channel: one 12-bit sensor sample per item (in_valid_i / in_ready_o).
// Output channel: one result item per completed block of SAMPLES_PER_BLOCK
// samples (out_valid_o / out_ready_i): average code, millivolts, lux,
// calibrated ambient percent, error, lamp duty and DAC code.
// APB port: desired percent at 0x0, system active at 0x4, deadband at 0x8.
// While system active is 0, samples are taken and dropped and the partial
// block is cleared; toggling system active clears it as well.
// Flow: a sample that does not close a block leaves in_ready_o high. The
// sample that closes a block starts five passes through one shared
// multiplier (operand product, reciprocal product, back product, then a
// one-step correction); the calibration pass is skipped at the ends of
// the range. in_ready_o stays low from that sample until the result is
// written into the output register.
// The result sits in an output register: if the receiver stalls, the block
// keeps taking samples and stalls only when the next result is done.
// Reset: desired 50, inactive, deadband 2, sum and count cleared, no result.
module light_level_block_controller
  import llbc_pkg::*;
#(
  parameter int unsigned SAMPLES_PER_BLOCK = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [11:0] sample_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [11:0] average_code_o,
  output logic [11:0] millivolts_o,
  output logic [9:0]  lux_o,
  output logic [6:0]  ambient_percent_o,
  output logic signed [7:0] error_percent_o,
  output logic [6:0]  duty_percent_o,
  output logic [9:0]  dac_code_o
);

  localparam int unsigned SUM_W = 12 + $clog2(SAMPLES_PER_BLOCK);
  localparam int unsigned CNT_W = (SAMPLES_PER_BLOCK > 1) ? $clog2(SAMPLES_PER_BLOCK) : 1;
  localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(SAMPLES_PER_BLOCK - 1);
  localparam logic [RCP_W-1:0] RCP_BLOCK = RCP_W'((1 << RCP_SH) / SAMPLES_PER_BLOCK);

  typedef enum logic [2:0] {
    S_IDLE,
    S_AVG,
    S_MV,
    S_LUX,
    S_SEG,
    S_DAC,
    S_OUT
  } state_e;

  typedef struct packed {
    logic             direct;
    logic [6:0]       pct;
    logic [11:0]      base_mv;
    logic [11:0]      span_mv;
    logic [RCP_W-1:0] rcp;
    logic [6:0]       base_pct;
    logic [4:0]       span_pct;
  } seg_t;

  // piecewise-linear mV -> percent calibration
  function automatic seg_t seg_lookup(input logic [11:0] mv);
    seg_t s;
    s = '0;
    if (mv == 12'd0) begin
      s.direct = 1'b1;
      s.pct    = 7'd0;
    end else if (mv <= 12'd425) begin
      s.direct = 1'b1;
      s.pct    = 7'd1;
    end else if (mv <= 12'd1087) begin
      s.base_mv = 12'd425;  s.span_mv = 12'd662; s.base_pct = 7'd1;  s.span_pct = 5'd19;
      s.rcp     = RCP_662;
    end else if (mv <= 12'd1436) begin
      s.base_mv = 12'd1087; s.span_mv = 12'd349; s.base_pct = 7'd20; s.span_pct = 5'd10;
      s.rcp     = RCP_349;
    end else if (mv <= 12'd2063) begin
      s.base_mv = 12'd1436; s.span_mv = 12'd627; s.base_pct = 7'd30; s.span_pct = 5'd20;
      s.rcp     = RCP_627;
    end else if (mv <= 12'd2718) begin
      s.base_mv = 12'd2063; s.span_mv = 12'd655; s.base_pct = 7'd50; s.span_pct = 5'd25;
      s.rcp     = RCP_655;
    end else if (mv <= 12'd3133) begin
      s.base_mv = 12'd2718; s.span_mv = 12'd415; s.base_pct = 7'd75; s.span_pct = 5'd25;
      s.rcp     = RCP_415;
    end else begin
      s.direct = 1'b1;
      s.pct    = 7'd100;
    end
    return s;
  endfunction

  state_e           state_q;
  logic             issued_q;
  logic [SUM_W-1:0] sum_q;
  logic [CNT_W-1:0] cnt_q;
  logic [6:0]       desired_q;
  logic             active_q;
  logic [6:0]       deadband_q;

  logic [11:0]      avg_q;
  logic [11:0]      mv_q;
  logic [9:0]       lux_q;
  logic [6:0]       amb_q;
  logic [9:0]       dac_q;

  logic             out_valid_q;
  logic [11:0]      out_avg_q;
  logic [11:0]      out_mv_q;
  logic [9:0]       out_lux_q;
  logic [6:0]       out_amb_q;
  logic [7:0]       out_err_q;
  logic [6:0]       out_duty_q;
  logic [9:0]       out_dac_q;

  llbc_req_t        req;
  llbc_rsp_t        rsp;
  seg_t             seg;
  logic             cfg_wr;
  logic [SUM_W-1:0] sum_next;
  logic [6:0]       desired_c;
  logic [7:0]       err;
  logic [6:0]       duty;

  llbc_muldiv u_muldiv (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .rsp_o  (rsp)
  );

  assign seg      = seg_lookup(mv_q);
  assign cfg_wr   = psel && penable && pwrite;
  assign sum_next = sum_q + SUM_W'(sample_i);

  // error and duty from the calibrated ambient level
  always_comb begin
    desired_c = (desired_q > 7'd100) ? 7'd100 : desired_q;
    err       = {1'b0, desired_c} - {1'b0, amb_q};
    if (err[7] || err == 8'd0) begin
      duty = 7'd0;
    end else if (desired_c > deadband_q && err <= {1'b0, deadband_q}) begin
      duty = 7'd0;
    end else if (err >= 8'd100) begin
      duty = 7'd100;
    end else begin
      duty = err[6:0];
    end
  end

  // operand select for the shared unit
  always_comb begin
    req       = '0;
    req.start = !issued_q && state_q != S_IDLE && state_q != S_OUT;
    case (state_q)
      S_AVG: begin
        req.a = A_W'(sum_q);
        req.b = B_W'(1);
        req.d = D_W'(SAMPLES_PER_BLOCK);
        req.m = RCP_BLOCK;
      end
      S_MV: begin
        req.a = A_W'(avg_q);
        req.b = B_W'(3300);
        req.d = D_W'(4095);
        req.m = RCP_4095;
      end
      S_LUX: begin
        req.a = A_W'(mv_q);
        req.b = B_W'(776);
        req.d = D_W'(3133);
        req.m = RCP_3133;
      end
      S_SEG: begin
        req.a = A_W'(mv_q - seg.base_mv);
        req.b = B_W'(seg.span_pct);
        req.d = seg.span_mv;
        req.m = seg.rcp;
      end
      S_DAC: begin
        req.a = A_W'(lux_q);
        req.b = B_W'(1023);
        req.d = D_W'(3300);
        req.m = RCP_3300;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      issued_q    <= 1'b0;
      sum_q       <= '0;
      cnt_q       <= '0;
      desired_q   <= 7'd50;
      active_q    <= 1'b0;
      deadband_q  <= 7'd2;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            if (!active_q) begin
              sum_q <= '0;
              cnt_q <= '0;
            end else if (cnt_q == LAST_CNT) begin
              sum_q   <= sum_next;
              cnt_q   <= '0;
              state_q <= S_AVG;
            end else begin
              sum_q <= sum_next;
              cnt_q <= cnt_q + 1'b1;
            end
          end
        end
        S_AVG, S_MV, S_LUX, S_SEG, S_DAC: begin
          if (!issued_q) begin
            issued_q <= 1'b1;
          end else if (rsp.done) begin
            issued_q <= 1'b0;
            unique case (state_q)
              S_AVG: begin
                avg_q   <= rsp.q;
                sum_q   <= '0;
                state_q <= S_MV;
              end
              S_MV: begin
                mv_q    <= rsp.q;
                state_q <= S_LUX;
              end
              S_LUX: begin
                lux_q <= rsp.q[9:0];
                if (seg.direct) begin
                  amb_q   <= seg.pct;
                  state_q <= S_DAC;
                end else begin
                  state_q <= S_SEG;
                end
              end
              S_SEG: begin
                amb_q   <= seg.base_pct + rsp.q[6:0];
                state_q <= S_DAC;
              end
              default: begin
                dac_q   <= (rsp.q > 12'd1023) ? 10'd1023 : rsp.q[9:0];
                state_q <= S_OUT;
              end
            endcase
          end
        end
        S_OUT: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q <= 1'b1;
            out_avg_q   <= avg_q;
            out_mv_q    <= mv_q;
            out_lux_q   <= lux_q;
            out_amb_q   <= amb_q;
            out_err_q   <= err;
            out_duty_q  <= duty;
            out_dac_q   <= dac_q;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase

      if (cfg_wr) begin
        unique case (paddr[3:2])
          REG_DESIRED:  desired_q <= pwdata[6:0];
          REG_ACTIVE: begin
            if (pwdata[0] != active_q) begin
              sum_q <= '0;
              cnt_q <= '0;
            end
            active_q <= pwdata[0];
          end
          REG_DEADBAND: deadband_q <= pwdata[6:0];
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    prdata = '0;
    unique case (paddr[3:2])
      REG_DESIRED:  prdata = 32'(desired_q);
      REG_ACTIVE:   prdata = 32'(active_q);
      REG_DEADBAND: prdata = 32'(deadband_q);
      default:      prdata = '0;
    endcase
  end

  assign pready            = 1'b1;
  assign in_ready_o        = (state_q == S_IDLE);
  assign out_valid_o       = out_valid_q;
  assign average_code_o    = out_avg_q;
  assign millivolts_o      = out_mv_q;
  assign lux_o             = out_lux_q;
  assign ambient_percent_o = out_amb_q;
  assign error_percent_o   = out_err_q;
  assign duty_percent_o    = out_duty_q;
  assign dac_code_o        = out_dac_q;

endmodule

### hw/rtl/llbc_muldiv.sv
module llbc_muldiv
  import llbc_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  llbc_req_t req_i,
  output llbc_rsp_t rsp_o
);

  localparam int unsigned PRD_W = NUM_W + RCP_W;

  typedef enum logic [2:0] {
    U_IDLE,
    U_MUL,
    U_RCP,
    U_BACK,
    U_FIX
  } ustate_e;

  ustate_e            state_q;
  logic [A_W-1:0]     a_q;
  logic [B_W-1:0]     b_q;
  logic [D_W-1:0]     d_q;
  logic [RCP_W-1:0]   m_q;
  logic [NUM_W-1:0]   num_q;
  logic [NUM_W-1:0]   rem_q;
  logic [Q_W-1:0]     quo_q;
  logic               done_q;

  logic [NUM_W-1:0]   mul_x;
  logic [RCP_W-1:0]   mul_y;
  logic [PRD_W-1:0]   prod;

  // one multiplier, operands picked by the current step
  always_comb begin
    mul_x = '0;
    mul_y = '0;
    unique case (state_q)
      U_MUL: begin
        mul_x = NUM_W'(a_q);
        mul_y = RCP_W'(b_q);
      end
      U_RCP: begin
        mul_x = num_q;
        mul_y = m_q;
      end
      U_BACK: begin
        mul_x = NUM_W'(quo_q);
        mul_y = RCP_W'(d_q);
      end
      default: ;
    endcase
  end

  assign prod = mul_x * mul_y;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= U_IDLE;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        U_IDLE: begin
          if (req_i.start) begin
            a_q     <= req_i.a;
            b_q     <= req_i.b;
            d_q     <= req_i.d;
            m_q     <= req_i.m;
            state_q <= U_MUL;
          end
        end
        U_MUL: begin
          num_q   <= prod[NUM_W-1:0];
          state_q <= U_RCP;
        end
        U_RCP: begin
          // quotient estimate, exact or one low
          quo_q   <= prod[RCP_SH +: Q_W];
          state_q <= U_BACK;
        end
        U_BACK: begin
          rem_q   <= num_q - prod[NUM_W-1:0];
          state_q <= U_FIX;
        end
        U_FIX: begin
          if (rem_q >= NUM_W'(d_q)) begin
            quo_q <= quo_q + 1'b1;
          end
          done_q  <= 1'b1;
          state_q <= U_IDLE;
        end
        default: state_q <= U_IDLE;
      endcase
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.q    = quo_q;

endmodule
